[src/drrip_pkg.sv]
// Shared types and constants for the DRRIP replacement policy unit.
// No dependencies; imported by every module of the block.
package drrip_pkg;

   // Geometry
   localparam int SET_COUNT = 4096;
   localparam int WAYS      = 16;
   localparam int MAX_CORES = 4;

   localparam int SET_W   = $clog2(SET_COUNT);
   localparam int WAY_W   = $clog2(WAYS);
   localparam int CORE_W  = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
   localparam int RRPV_W  = 8;
   localparam int GRP_N   = (WAYS + 3) / 4;

   // Port widths fixed by the interface
   localparam int SET_IN_W = 12;
   localparam int WAY_IN_W = 4;
   localparam int CNT_W    = 10;

   // Policy counter
   localparam logic [CNT_W-1:0] CNT_RESET      = 10'h1FF;
   localparam logic [CNT_W-1:0] CNT_TOP        = 10'd1023;
   localparam int               CNT_POLICY_BIT = 9;

   // Set-dueling hash: upper bits [11:7], lower bits [6:0]
   localparam int HASH_SHIFT = 7;

   // Reset value of every stored re-reference value
   localparam logic [RRPV_W-1:0] RRPV_RESET = 8'd7;

   // Configuration register indexes
   localparam logic CSR_RRPV_BITS    = 1'b0;
   localparam logic CSR_ACTIVE_CORES = 1'b1;

   typedef logic [WAYS-1:0][RRPV_W-1:0] row_type;

   localparam row_type ROW_RESET = row_type'({WAYS{RRPV_RESET}});

   // Access to the row memory
   typedef struct packed {
      logic             rd_en;
      logic [SET_W-1:0] rd_addr;
      logic             wr_en;
      logic [SET_W-1:0] wr_addr;
      row_type          wr_data;
   } store_req_type;

   // Controls for the victim / update datapath
   typedef struct packed {
      logic              func;
      logic              hit_ok;
      logic [WAY_W-1:0]  hit_idx;
      logic [RRPV_W-1:0] mx;
      logic [RRPV_W-1:0] ins;
   } victim_ctl_type;

endpackage

[src/drrip_store.sv]
// Row memory: one word per set holding the values of all ways.
// Uses drrip_pkg. Runs a clearing sweep after reset.
module drrip_store (
   input  logic                   clock,
   input  logic                   reset,
   input  drrip_pkg::store_req_type req,
   output drrip_pkg::row_type     rd_data,
   output logic                   busy
);
   import drrip_pkg::*;

   localparam logic [SET_W-1:0] SET_LAST = SET_W'(SET_COUNT - 1);

   row_type          store_mem [SET_COUNT];
   row_type          rd_data_ff;
   logic             clr_busy_ff;
   logic [SET_W-1:0] clr_addr_ff;

   logic             wen;
   logic [SET_W-1:0] waddr;
   row_type          wdata;

   // Clearing sweep owns the write port while active
   always_comb begin
      wen   = clr_busy_ff | req.wr_en;
      waddr = clr_busy_ff ? clr_addr_ff : req.wr_addr;
      wdata = clr_busy_ff ? ROW_RESET : req.wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == SET_LAST) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Memory array, registered read
   always_ff @(posedge clock) begin
      if (wen) begin
         store_mem[waddr] <= wdata;
      end
      if (req.rd_en) begin
         rd_data_ff <= store_mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

[src/drrip_victim.sv]
// Victim search and row update: registered group maxima, then aging,
// priority pick and write-back row. Uses drrip_pkg.
module drrip_victim (
   input  logic                      clock,
   input  logic                      load,
   input  drrip_pkg::row_type        row_in,
   input  drrip_pkg::victim_ctl_type ctl,
   output logic [drrip_pkg::WAY_W-1:0] victim,
   output drrip_pkg::row_type        row_out
);
   import drrip_pkg::*;

   row_type                       row_ff;
   logic [GRP_N-1:0][RRPV_W-1:0]  grp_max_ff;
   logic [GRP_N-1:0][RRPV_W-1:0]  grp_max_in;

   logic [RRPV_W-1:0] top;
   logic              aging;
   logic [RRPV_W-1:0] delta;
   logic [WAYS-1:0]   match;
   logic              found;

   // Stage 1: max of each group of four ways
   always_comb begin
      for (int g = 0; g < GRP_N; g++) begin
         grp_max_in[g] = '0;
         for (int k = 0; k < 4; k++) begin
            if (g * 4 + k < WAYS) begin
               if (row_in[g * 4 + k] > grp_max_in[g]) begin
                  grp_max_in[g] = row_in[g * 4 + k];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff     <= row_in;
         grp_max_ff <= grp_max_in;
      end
   end

   // Stage 2: overall max, aging amount and candidate ways
   always_comb begin
      top = '0;
      for (int g = 0; g < GRP_N; g++) begin
         if (grp_max_ff[g] > top) begin
            top = grp_max_ff[g];
         end
      end
      aging = (top < ctl.mx);
      delta = ctl.mx - top;
      for (int w = 0; w < WAYS; w++) begin
         match[w] = aging ? (row_ff[w] == top) : (row_ff[w] >= ctl.mx);
      end
   end

   // First matching way wins
   always_comb begin
      victim = '0;
      found  = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (match[w] && !found) begin
            victim = WAY_W'(w);
            found  = 1'b1;
         end
      end
   end

   // New row: hit decrements one way, miss ages all when no way is at max and inserts the victim
   always_comb begin
      row_out = row_ff;
      if (!ctl.func) begin
         if (ctl.hit_ok && row_ff[ctl.hit_idx] != '0) begin
            row_out[ctl.hit_idx] = row_ff[ctl.hit_idx] - 1'b1;
         end
      end else begin
         if (aging) begin
            for (int w = 0; w < WAYS; w++) begin
               row_out[w] = row_ff[w] + delta;
            end
         end
         row_out[victim] = ctl.ins;
      end
   end

endmodule

[src/drrip_replacement_policy_unit.sv]
// DRRIP replacement policy unit: top level with control, policy counters
// and result register. Uses drrip_pkg, drrip_store and drrip_victim.
//
// Usage:
//   req_* carries one access item (hit update or miss) under valid/ready.
//   rsp_* returns one result item per access: victim way, insertion value
//   and the BRRIP flag on a miss, all zero on a hit.
//   csr_* writes rrpv_bits (index 0) or active_cores (index 1), one per write;
//   write only while no item is in flight.
// Timing:
//   An item is accepted, its set row is read from the row memory into a
//   register, the group maxima are registered, then the victim is chosen,
//   the row written back and the result registered. The next item is
//   taken in the cycle the current one writes back, so a new item is not
//   accepted before the current one's read-compute-write loop on the row
//   memory is through; a back-to-back access to the same set takes the
//   written row by forwarding.
// Reset and stalls:
//   After reset a sweep writes the reset value into all 4096 rows, one row
//   a cycle; req_ready stays low until the sweep is done. If rsp_ready is low
//   the finished result holds in the output register, and a further item
//   waits at its last step until the register frees up.
module drrip_replacement_policy_unit (
   input  logic                           clock,
   input  logic                           reset,
   // access channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic [drrip_pkg::SET_IN_W-1:0] req_set_index,
   input  logic [1:0]                     req_core_id,
   input  logic [drrip_pkg::WAY_IN_W-1:0] req_hit_way,
   input  logic [4:0]                     req_random_draw,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [3:0]                     rsp_victim_way,
   output logic [7:0]                     rsp_insert_value,
   output logic                           rsp_used_brrip,
   // configuration
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [3:0]                     csr_wdata
);
   import drrip_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_LOAD = 3'b010,
      S_CALC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic [3:0] rrpv_bits_ff;
   logic [2:0] active_cores_ff;

   // Captured item
   logic              func_ff;
   logic [SET_W-1:0]  set_ff;
   logic [CORE_W-1:0] core_ff;
   logic              hit_ok_ff;
   logic [WAY_W-1:0]  hit_idx_ff;
   logic [4:0]        draw_ff;

   // Forwarding of a row written in the cycle its next read is issued
   logic    fwd_ff;
   row_type fwd_row_ff;

   // Policy counters
   logic [MAX_CORES-1:0][CNT_W-1:0] cnt_ff;

   // Result register
   logic        rsp_valid_ff;
   logic [3:0]  rsp_victim_ff;
   logic [7:0]  rsp_insert_ff;
   logic        rsp_brrip_ff;

   logic              acc;
   logic              out_free;
   logic              calc_done;
   logic [SET_W-1:0]  req_set;
   logic              store_busy;
   store_req_type     store_req;
   row_type           rd_row;
   row_type           new_row;
   logic [WAY_W-1:0]  victim;
   victim_ctl_type    vctl;

   logic [3:0]        bits_eff;
   logic [3:0]        cores_eff;
   logic [RRPV_W-1:0] mx;
   logic [SET_IN_W-1:0] set12;
   logic [7:0]        hash_up;
   logic [7:0]        hash_lo;
   logic [7:0]        sum_s;
   logic [7:0]        sum_b;
   logic              lead_s;
   logic              lead_b;
   logic              brrip;
   logic [RRPV_W-1:0] ins;
   logic [CNT_W-1:0]  cnt_cur;

   // Handshake and sequencing
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign calc_done = (state_ff == S_CALC) && out_free;
   assign req_ready = !store_busy && ((state_ff == S_IDLE) || calc_done);
   assign acc       = req_valid && req_ready;
   assign req_set   = SET_W'(req_set_index);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc) state_in = S_LOAD;
         end
         S_LOAD: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            if (calc_done) state_in = acc ? S_LOAD : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fwd_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fwd_ff   <= acc && calc_done && (req_set == set_ff);
      end
   end

   // Capture the item and the row being written back
   always_ff @(posedge clock) begin
      if (acc) begin
         func_ff    <= req_func;
         set_ff     <= req_set;
         core_ff    <= CORE_W'(req_core_id);
         hit_ok_ff  <= 8'(req_hit_way) < 8'(WAYS);
         hit_idx_ff <= WAY_W'(req_hit_way);
         draw_ff    <= req_random_draw;
         fwd_row_ff <= new_row;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rrpv_bits_ff    <= 4'd3;
         active_cores_ff <= 3'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RRPV_BITS:    rrpv_bits_ff    <= csr_wdata;
            CSR_ACTIVE_CORES: active_cores_ff <= csr_wdata[2:0];
            default:          ;
         endcase
      end
   end

   // Clamped configuration values
   always_comb begin
      bits_eff = (rrpv_bits_ff == 4'd0) ? 4'd1 :
                 (rrpv_bits_ff > 4'd8)  ? 4'd8 : rrpv_bits_ff;
      cores_eff = (active_cores_ff == 3'd0) ? 4'd1 :
                  (4'(active_cores_ff) > 4'(MAX_CORES)) ? 4'(MAX_CORES) :
                  4'(active_cores_ff);
      mx = RRPV_W'((9'd1 << bits_eff) - 9'd1);
   end

   // Set dueling and insertion value
   always_comb begin
      set12   = SET_IN_W'(set_ff);
      hash_up = 8'(set12[SET_IN_W-1:HASH_SHIFT]);
      hash_lo = 8'(set12[HASH_SHIFT-1:0]);
      sum_s   = hash_up + 8'(core_ff);
      sum_b   = sum_s + 8'(cores_eff);
      lead_s  = (sum_s == hash_lo);
      lead_b  = !lead_s && (sum_b == hash_lo);
      cnt_cur = cnt_ff[core_ff];
      brrip   = lead_s ? 1'b0 : lead_b ? 1'b1 : cnt_cur[CNT_POLICY_BIT];
      ins     = (brrip && draw_ff != 5'd0) ? mx : mx - 1'b1;
   end

   // Policy counters move on misses in leader sets
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAX_CORES; c++) begin
            cnt_ff[c] <= CNT_RESET;
         end
      end else if (calc_done && func_ff) begin
         if (lead_s && cnt_cur < CNT_TOP) begin
            cnt_ff[core_ff] <= cnt_cur + 1'b1;
         end else if (lead_b && cnt_cur != '0) begin
            cnt_ff[core_ff] <= cnt_cur - 1'b1;
         end
      end
   end

   // Row memory
   always_comb begin
      store_req.rd_en   = acc;
      store_req.rd_addr = req_set;
      store_req.wr_en   = calc_done;
      store_req.wr_addr = set_ff;
      store_req.wr_data = new_row;
   end

   drrip_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .rd_data (rd_row),
      .busy    (store_busy)
   );

   // Victim datapath
   always_comb begin
      vctl.func    = func_ff;
      vctl.hit_ok  = hit_ok_ff;
      vctl.hit_idx = hit_idx_ff;
      vctl.mx      = mx;
      vctl.ins     = ins;
   end

   drrip_victim u_victim (
      .clock   (clock),
      .load    (state_ff == S_LOAD),
      .row_in  (fwd_ff ? fwd_row_ff : rd_row),
      .ctl     (vctl),
      .victim  (victim),
      .row_out (new_row)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (calc_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (calc_done) begin
         rsp_victim_ff <= func_ff ? 4'(victim) : 4'd0;
         rsp_insert_ff <= func_ff ? 8'(ins) : 8'd0;
         rsp_brrip_ff  <= func_ff && brrip;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_victim_way   = rsp_victim_ff;
   assign rsp_insert_value = rsp_insert_ff;
   assign rsp_used_brrip   = rsp_brrip_ff;

   // Checks
   a_no_acc_while_clearing : assert property (@(posedge clock) disable iff (reset)
      acc |-> !store_busy)
      else $error("item accepted during clearing sweep");

   a_acc_starts_load : assert property (@(posedge clock) disable iff (reset)
      acc |=> (state_ff == S_LOAD))
      else $error("accepted item did not start a row read");

   a_fwd_after_calc : assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> $past(calc_done))
      else $error("forwarded row without a write-back");

   a_no_result_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !calc_done)
      else $error("pending result overwritten");

endmodule

[test/drrip_replacement_policy_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for drrip_replacement_policy_unit: directed table, then
// randomized access phases under several register settings, checked by a local predictor.
// Depends on drrip_pkg and the unit's RTL only.
module drrip_replacement_policy_unit_test;
   import drrip_pkg::*;

   // Access codes and set-dueling classes
   localparam logic FUNC_HIT  = 1'b0;
   localparam logic FUNC_MISS = 1'b1;
   localparam int   HOT_N     = 8;
   localparam int   DIR_N     = 17;
   localparam int   PHASE_N   = 5;

   typedef enum logic [1:0] {DUEL_FOLLOWER, DUEL_SRRIP, DUEL_BRRIP} duel_kind_type;

   typedef struct packed {
      logic        func;
      logic [11:0] set_index;
      logic [1:0]  core_id;
      logic [3:0]  hit_way;
      logic [4:0]  random_draw;
   } access_item_type;

   typedef struct packed {
      logic [3:0] victim_way;
      logic [7:0] insert_value;
      logic       used_brrip;
   } access_result_type;

   typedef struct packed {
      logic        func;
      logic [11:0] set_index;
      logic [1:0]  core_id;
      logic [3:0]  hit_way;
      logic [4:0]  random_draw;
      logic        known;
      logic [3:0]  exp_victim;
      logic [7:0]  exp_insert;
      logic        exp_brrip;
   } dir_row_type;

   typedef struct packed {
      logic [3:0]    rrpv_bits;
      logic [2:0]    cores;
      logic [10:0]   count;
      logic [1:0]    drift_core;
      duel_kind_type drift_kind;
      logic [6:0]    drift_pct;
      logic          send_idle;
      logic          rsp_idle;
   } phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [11:0] req_set_index = '0;
   logic [1:0]  req_core_id = '0;
   logic [3:0]  req_hit_way = '0;
   logic [4:0]  req_random_draw = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_victim_way;
   logic [7:0]  rsp_insert_value;
   logic        rsp_used_brrip;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [3:0]  csr_wdata = '0;

   // Predictor state
   logic [7:0]  rrpv_mirror [SET_COUNT][WAYS];
   logic [9:0]  psel_mirror [MAX_CORES];
   logic [3:0]  cfg_rrpv_bits;
   logic [2:0]  cfg_cores;

   access_result_type pending_results [$];
   logic [11:0]       hot_sets [HOT_N];

   int mismatch_count = 0;
   int hit_count = 0;
   int miss_count = 0;
   int brrip_fills = 0;
   int setting_count = 1;
   int stall_left = 0;
   bit send_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   // Directed table; expected values typed in only where plain from the reset state
   dir_row_type dir_rows [DIR_N] = '{
      '{FUNC_MISS, 12'h000, 2'd0, 4'd0,  5'd0,  1'b1, 4'd0, 8'd6, 1'b0},  // SRRIP leader
      '{FUNC_MISS, 12'h001, 2'd0, 4'd0,  5'd0,  1'b1, 4'd0, 8'd6, 1'b1},  // BRRIP leader, near
      '{FUNC_MISS, 12'h001, 2'd0, 4'd0,  5'd31, 1'b1, 4'd1, 8'd7, 1'b1},  // BRRIP leader, distant
      '{FUNC_MISS, 12'hFFF, 2'd3, 4'd15, 5'd31, 1'b1, 4'd0, 8'd6, 1'b0},  // core above active
      '{FUNC_HIT,  12'hFFF, 2'd3, 4'd0,  5'd0,  1'b1, 4'd0, 8'd0, 1'b0},
      '{FUNC_HIT,  12'hFFF, 2'd0, 4'd15, 5'd31, 1'b1, 4'd0, 8'd0, 1'b0},
      '{FUNC_MISS, 12'hFFF, 2'd3, 4'd0,  5'd0,  1'b0, 4'd0, 8'd0, 1'b0},
      '{FUNC_MISS, 12'h082, 2'd1, 4'd0,  5'd5,  1'b1, 4'd0, 8'd6, 1'b0},  // core 1 SRRIP leader
      '{FUNC_MISS, 12'h105, 2'd2, 4'd0,  5'd17, 1'b1, 4'd0, 8'd7, 1'b1},  // core 2 BRRIP leader
      '{FUNC_MISS, 12'h555, 2'd0, 4'd5,  5'd10, 1'b0, 4'd0, 8'd0, 1'b0},
      '{FUNC_MISS, 12'h082, 2'd3, 4'd0,  5'd0,  1'b0, 4'd0, 8'd0, 1'b0},
      '{FUNC_MISS, 12'h082, 2'd1, 4'd0,  5'd0,  1'b0, 4'd0, 8'd0, 1'b0},
      '{FUNC_MISS, 12'h7A3, 2'd1, 4'd0,  5'd9,  1'b0, 4'd0, 8'd0, 1'b0},  // follower on BRRIP
      '{FUNC_HIT,  12'h001, 2'd2, 4'd1,  5'd0,  1'b1, 4'd0, 8'd0, 1'b0},
      '{FUNC_HIT,  12'h000, 2'd0, 4'd0,  5'd0,  1'b1, 4'd0, 8'd0, 1'b0},
      '{FUNC_MISS, 12'h001, 2'd2, 4'd0,  5'd0,  1'b0, 4'd0, 8'd0, 1'b0},
      '{FUNC_HIT,  12'hAAA, 2'd2, 4'd10, 5'd21, 1'b1, 4'd0, 8'd0, 1'b0}
   };

   // Random phases: register setting, length, and which counter is pushed
   phase_type phases [PHASE_N] = '{
      '{4'd8,  3'd4, 11'd350, 2'd0, DUEL_SRRIP, 7'd80, 1'b1, 1'b1},
      '{4'd2,  3'd0, 11'd330, 2'd0, DUEL_SRRIP, 7'd80, 1'b0, 1'b0},
      '{4'd15, 3'd7, 11'd230, 2'd1, DUEL_BRRIP, 7'd50, 1'b1, 1'b0},
      '{4'd0,  3'd2, 11'd220, 2'd2, DUEL_SRRIP, 7'd30, 1'b1, 1'b1},
      '{4'd5,  3'd3, 11'd220, 2'd3, DUEL_BRRIP, 7'd30, 1'b0, 1'b1}
   };

   drrip_replacement_policy_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_set_index    (req_set_index),
      .req_core_id      (req_core_id),
      .req_hit_way      (req_hit_way),
      .req_random_draw  (req_random_draw),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_victim_way   (rsp_victim_way),
      .rsp_insert_value (rsp_insert_value),
      .rsp_used_brrip   (rsp_used_brrip),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // One line per mismatch, counted
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR @%0t: %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Effective RRPV maximum and core count, clamped as the unit does
   function automatic int unsigned rrpv_limit();
      int unsigned b;
      b = cfg_rrpv_bits;
      if (b < 1) b = 1;
      if (b > 8) b = 8;
      return (1 << b) - 1;
   endfunction

   function automatic int unsigned eff_cores();
      int unsigned c;
      c = cfg_cores;
      if (c < 1) c = 1;
      if (c > MAX_CORES) c = MAX_CORES;
      return c;
   endfunction

   function automatic duel_kind_type duel_kind(input logic [11:0] set_index,
                                               input logic [1:0] core);
      int unsigned upper, lower;
      upper = set_index[11:7];
      lower = set_index[6:0];
      if (upper + core == lower) return DUEL_SRRIP;
      if (upper + core + eff_cores() == lower) return DUEL_BRRIP;
      return DUEL_FOLLOWER;
   endfunction

   // Replacement-state predictor: updates the mirror, returns the result item
   function automatic access_result_type predict_access(input access_item_type it);
      int unsigned       mx, top, victim;
      logic [7:0]        ins;
      duel_kind_type     kind;
      logic              brrip;
      bit                found;
      access_result_type res;
      res = '0;
      if (it.func == FUNC_HIT) begin
         if (int'(it.hit_way) < WAYS && rrpv_mirror[it.set_index][it.hit_way] != 8'd0)
            rrpv_mirror[it.set_index][it.hit_way] = rrpv_mirror[it.set_index][it.hit_way] - 8'd1;
         return res;
      end
      mx = rrpv_limit();
      kind = duel_kind(it.set_index, it.core_id);
      case (kind)
         DUEL_SRRIP: brrip = 1'b0;
         DUEL_BRRIP: brrip = 1'b1;
         default:    brrip = psel_mirror[it.core_id][CNT_POLICY_BIT];
      endcase
      ins = (brrip && it.random_draw != 5'd0) ? 8'(mx) : 8'(mx - 1);
      // Leader misses move the core's counter, saturating both ways
      if (kind == DUEL_SRRIP && psel_mirror[it.core_id] < CNT_TOP)
         psel_mirror[it.core_id] = psel_mirror[it.core_id] + 10'd1;
      else if (kind == DUEL_BRRIP && psel_mirror[it.core_id] != 10'd0)
         psel_mirror[it.core_id] = psel_mirror[it.core_id] - 10'd1;
      // Age the row until some way sits at max; stale values above max are left alone
      top = 0;
      for (int w = 0; w < WAYS; w++)
         if (rrpv_mirror[it.set_index][w] > top) top = rrpv_mirror[it.set_index][w];
      if (top < mx)
         for (int w = 0; w < WAYS; w++)
            rrpv_mirror[it.set_index][w] = rrpv_mirror[it.set_index][w] + 8'(mx - top);
      victim = 0;
      found = 1'b0;
      for (int w = 0; w < WAYS; w++)
         if (!found && rrpv_mirror[it.set_index][w] >= mx) begin
            victim = w;
            found = 1'b1;
         end
      rrpv_mirror[it.set_index][victim] = ins;
      res.victim_way = 4'(victim);
      res.insert_value = ins;
      res.used_brrip = brrip;
      return res;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [11:0] leader_set(input logic [1:0] core,
                                              input duel_kind_type kind);
      int unsigned upper, lower;
      upper = $urandom_range(0, 31);
      lower = upper + core + ((kind == DUEL_BRRIP) ? eff_cores() : 0);
      return {upper[4:0], lower[6:0]};
   endfunction

   // Random access: mostly leader misses that push one counter, plus mixed traffic
   function automatic access_item_type make_item(input phase_type ph);
      access_item_type it;
      int unsigned     pick;
      it.core_id = 2'($urandom_range(0, 3));
      it.hit_way = 4'($urandom_range(0, 15));
      it.random_draw = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(0, 31));
      it.func = FUNC_MISS;
      pick = $urandom_range(0, 99);
      if (pick < ph.drift_pct) begin
         it.core_id = ph.drift_core;
         it.set_index = leader_set(it.core_id, ph.drift_kind);
      end else begin
         if ($urandom_range(0, 99) < 40) it.func = FUNC_HIT;
         pick = $urandom_range(0, 99);
         if (pick < 25)
            it.set_index = leader_set(it.core_id,
                                      ($urandom_range(0, 1) != 0) ? DUEL_SRRIP : DUEL_BRRIP);
         else if (pick < 70)
            it.set_index = hot_sets[$urandom_range(0, HOT_N - 1)];
         else
            it.set_index = 12'($urandom);
      end
      if (it.func == FUNC_MISS) hot_sets[$urandom_range(0, HOT_N - 1)] = it.set_index;
      return it;
   endfunction

   // Present one item, wait for acceptance, queue its expected result
   task automatic send_access(input access_item_type it, input bit known,
                              input access_result_type typed);
      access_result_type res;
      req_valid <= 1'b1;
      req_func <= it.func;
      req_set_index <= it.set_index;
      req_core_id <= it.core_id;
      req_hit_way <= it.hit_way;
      req_random_draw <= it.random_draw;
      do @(posedge clock); while (!req_ready);
      res = predict_access(it);
      pending_results.push_back(known ? typed : res);
      if (it.func == FUNC_HIT) hit_count++;
      else miss_count++;
      if (res.used_brrip) brrip_fills++;
   endtask

   task automatic idle_sender();
      int gap;
      if (send_idle_on && $urandom_range(0, 99) < 30) begin
         gap = pick_gap();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Both registers in back-to-back cycles; unit must be idle
   task automatic set_config(input logic [3:0] rrpv_bits, input logic [2:0] cores);
      csr_we <= 1'b1;
      csr_index <= CSR_RRPV_BITS;
      csr_wdata <= rrpv_bits;
      @(posedge clock);
      csr_index <= CSR_ACTIVE_CORES;
      csr_wdata <= {1'b0, cores};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_rrpv_bits = rrpv_bits;
      cfg_cores = cores;
      setting_count++;
   endtask

   // Result side: random stalls, compare against oldest expectation
   always @(posedge clock) begin
      access_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result item with nothing pending", 32'(rsp_victim_way), 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_victim_way !== want.victim_way)
               report_mismatch("victim_way", 32'(rsp_victim_way), 32'(want.victim_way));
            if (rsp_insert_value !== want.insert_value)
               report_mismatch("insert_value", 32'(rsp_insert_value),
                               32'(want.insert_value));
            if (rsp_used_brrip !== want.used_brrip)
               report_mismatch("used_brrip", 32'(rsp_used_brrip), 32'(want.used_brrip));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 99) < 20) begin
         stall_left = pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Run limit
   initial begin
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Stimulus
   initial begin
      access_item_type it;
      cfg_rrpv_bits = 4'd3;
      cfg_cores = 3'd1;
      for (int s = 0; s < SET_COUNT; s++)
         for (int w = 0; w < WAYS; w++)
            rrpv_mirror[s][w] = RRPV_RESET;
      for (int c = 0; c < MAX_CORES; c++) psel_mirror[c] = CNT_RESET;
      for (int h = 0; h < HOT_N; h++) hot_sets[h] = 12'($urandom);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table at reset settings
      for (int i = 0; i < DIR_N; i++) begin
         it = '{dir_rows[i].func, dir_rows[i].set_index, dir_rows[i].core_id,
                dir_rows[i].hit_way, dir_rows[i].random_draw};
         send_access(it, dir_rows[i].known,
                     '{dir_rows[i].exp_victim, dir_rows[i].exp_insert, dir_rows[i].exp_brrip});
         idle_sender();
      end

      // Random phases, each under its own register setting
      for (int p = 0; p < PHASE_N; p++) begin
         drain_results();
         repeat (4) @(posedge clock);
         set_config(phases[p].rrpv_bits, phases[p].cores);
         send_idle_on = phases[p].send_idle;
         rsp_idle_on = phases[p].rsp_idle;
         for (int i = 0; i < phases[p].count; i++) begin
            it = make_item(phases[p]);
            send_access(it, 1'b0, '0);
            if (i == phases[p].count / 2 || $urandom_range(0, 199) == 0)
               drain_results();
            else
               idle_sender();
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("result items never returned", 32'(pending_results.size()), 32'd0);

      $display("Ran %0d accesses (%0d hits, %0d misses, %0d BRRIP fills) over %0d settings",
               hit_count + miss_count, hit_count, miss_count, brrip_fills, setting_count);
      $display("Policy counters at end: %0d %0d %0d %0d",
               psel_mirror[0], psel_mirror[1], psel_mirror[2], psel_mirror[3]);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
